@@ design/ber_primitive_tlv_encoder_assert.svh @@
// Assertion macros for the BER primitive TLV encoder.
// Used by files that check their own logic; expects clk_i and rst_ni in scope.
`ifndef BER_PRIMITIVE_TLV_ENCODER_ASSERT_SVH
`define BER_PRIMITIVE_TLV_ENCODER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define TLV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next
`define TLV_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TLV_ASSERT(label, prop, msg)
`define TLV_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ design/ber_tlv_pkg.sv @@
// Shared types, command codes and a helper function of the BER TLV encoder.
// No dependencies.
`timescale 1ns / 1ps

package ber_tlv_pkg;

  localparam int unsigned MaxBytes = 7;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam logic [7:0]  LenShortMax = 8'd127;
  localparam logic [7:0]  LenLong1    = 8'h81;
  localparam logic [7:0]  LenLong2    = 8'h82;
  localparam logic [7:0]  LenLong3    = 8'h83;
  localparam logic [7:0]  BoolTrue    = 8'hff;
  localparam logic [7:0]  BoolFalse   = 8'h00;
  localparam logic [7:0]  BoolLen     = 8'h01;
  localparam logic [23:0] LenSatMax   = 24'hffffff;

  typedef enum logic [2:0] {
    CmdLen    = 3'd0,
    CmdTagLen = 3'd1,
    CmdBool   = 3'd2,
    CmdUint   = 3'd3,
    CmdInt    = 3'd4,
    CmdUintTl = 3'd5
  } cmd_e;

  typedef logic [CntW-1:0] cnt_t;

  // Octet sequence, first octet in the top byte
  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    cnt_t                  count;
  } tlv_seq_t;

  // Count redundant leading octets of a big-endian string of sz octets
  // (left aligned in raw), keeping at least one octet.
  function automatic logic [2:0] lead_skip(logic [39:0] raw, logic [2:0] sz);
    logic [2:0] s;
    logic       stop;
    logic [7:0] cur;
    logic [7:0] nxt;
    s    = 3'd0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cur = raw[39-8*i -: 8];
      nxt = raw[31-8*i -: 8];
      if (!stop && (3'(i) < sz - 3'd1)) begin
        if ((cur == 8'h00 && !nxt[7]) || (cur == 8'hff && nxt[7])) begin
          s = s + 3'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return s;
  endfunction

endpackage

@@ design/ber_tlv_encode.sv @@
// Combinational builder of the full octet sequence for one command.
// Depends on ber_tlv_pkg.
`timescale 1ns / 1ps

module ber_tlv_encode
  import ber_tlv_pkg::*;
(
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  tag_i,
  input  logic [31:0] value_word_i,
  output tlv_seq_t    seq_o
);

  logic [23:0] len_sat;
  logic [31:0] len_seq;
  cnt_t        len_n;
  logic [39:0] uint_raw;
  logic [2:0]  uint_skip;
  logic [39:0] uint_cont;
  logic [2:0]  uint_n;
  logic [39:0] int_raw;
  logic [2:0]  int_skip;
  logic [39:0] int_cont;
  logic [2:0]  int_n;
  logic [7:0]  bool_byte;

  // Saturate and pick the length form
  always_comb begin
    len_sat = (value_word_i[31:24] != 8'h00) ? LenSatMax : value_word_i[23:0];
    if (len_sat <= {16'h0, LenShortMax}) begin
      len_seq = {len_sat[7:0], 24'h0};
      len_n   = cnt_t'(1);
    end else if (len_sat[23:8] == 16'h0) begin
      len_seq = {LenLong1, len_sat[7:0], 16'h0};
      len_n   = cnt_t'(2);
    end else if (len_sat[23:16] == 8'h0) begin
      len_seq = {LenLong2, len_sat[15:0], 8'h0};
      len_n   = cnt_t'(3);
    end else begin
      len_seq = {LenLong3, len_sat};
      len_n   = cnt_t'(4);
    end
  end

  // Minimal integer content (unsigned with an implicit leading zero octet, and signed) and the boolean octet
  always_comb begin
    uint_raw  = {8'h00, value_word_i};
    uint_skip = lead_skip(uint_raw, 3'd5);
    uint_cont = uint_raw << (8 * uint_skip);
    uint_n    = 3'd5 - uint_skip;
    int_raw   = {value_word_i, 8'h00};
    int_skip  = lead_skip(int_raw, 3'd4);
    int_cont  = int_raw << (8 * int_skip);
    int_n     = 3'd4 - int_skip;
    bool_byte = (value_word_i != 32'h0) ? BoolTrue : BoolFalse;
  end

  // Assemble the sequence per command; unknown codes give no octets
  always_comb begin
    case (cmd_e'(cmd_i))
      CmdLen: begin
        seq_o.bytes = {len_seq, 24'h0};
        seq_o.count = len_n;
      end
      CmdTagLen: begin
        seq_o.bytes = {tag_i, len_seq, 16'h0};
        seq_o.count = len_n + cnt_t'(1);
      end
      CmdBool: begin
        seq_o.bytes = {tag_i, BoolLen, bool_byte, 32'h0};
        seq_o.count = cnt_t'(3);
      end
      CmdUint: begin
        seq_o.bytes = {uint_cont, 16'h0};
        seq_o.count = cnt_t'(uint_n);
      end
      CmdInt: begin
        seq_o.bytes = {int_cont[39:8], 24'h0};
        seq_o.count = cnt_t'(int_n);
      end
      CmdUintTl: begin
        seq_o.bytes = {tag_i, 5'b0, uint_n, uint_cont};
        seq_o.count = cnt_t'(uint_n) + cnt_t'(2);
      end
      default: begin
        seq_o.bytes = '0;
        seq_o.count = '0;
      end
    endcase
  end

endmodule

@@ design/ber_tlv_emit.sv @@
// Result buffer that shifts out one octet per accepted output request.
// Depends on ber_tlv_pkg.
`timescale 1ns / 1ps

module ber_tlv_emit
  import ber_tlv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tlv_seq_t   seq_i,
  input  logic       seq_valid_i,
  output logic       load_o,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic [8*MaxBytes-1:0] seq_d, seq_q;
  cnt_t                  cnt_d, cnt_q;
  logic                  pop;

  // Reload when empty or when the final octet leaves this cycle
  assign pop    = out_valid_o && out_ready_i;
  assign load_o = seq_valid_i && ((cnt_q == '0) || ((cnt_q == cnt_t'(1)) && out_ready_i));

  always_comb begin
    seq_d = seq_q;
    cnt_d = cnt_q;
    if (load_o) begin
      seq_d = seq_i.bytes;
      cnt_d = seq_i.count;
    end else if (pop) begin
      seq_d = seq_q << 8;
      cnt_d = cnt_q - cnt_t'(1);
    end
  end

  // Hold octet count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold octet payload
  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = seq_q[8*MaxBytes-1 -: 8];
  assign last_byte_o = (cnt_q == cnt_t'(1));

endmodule

@@ design/ber_primitive_tlv_encoder.sv @@
// BER primitive TLV encoder: one command in, its BER octets out one per cycle while out_ready_i is high.
// Path: the request is registered, then loaded into the result buffer once that is free, which drives its first octet.
// Throughput: one octet per cycle while out_ready_i is high; a command holds the output for its 1 to 7
// octets, and commands with no octets pass at one per cycle.
// Reset: asynchronous active low, clears the input and output valid state.
// Depends on ber_tlv_pkg, ber_tlv_encode, ber_tlv_emit and ber_primitive_tlv_encoder_assert.svh.
`timescale 1ns / 1ps
`include "ber_primitive_tlv_encoder_assert.svh"

module ber_primitive_tlv_encoder
  import ber_tlv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  tag_i,
  input  logic [31:0] value_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [7:0]  tag_q;
  logic [31:0] value_q;
  tlv_seq_t    seq;
  logic        load;

  // Take a new request when none is held or the held one moves on this cycle
  assign in_ready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold request payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      tag_q   <= tag_i;
      value_q <= value_word_i;
    end
  end

  ber_tlv_encode u_encode (
    .cmd_i        (cmd_q),
    .tag_i        (tag_q),
    .value_word_i (value_q),
    .seq_o        (seq)
  );

  ber_tlv_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_i       (seq),
    .seq_valid_i (in_valid_q),
    .load_o      (load),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // Checks on sequencing
  `TLV_ASSERT(a_no_reload_mid_seq, !(out_valid_o && !last_byte_o && load), "reload mid sequence")
  `TLV_ASSERT_NEXT(a_seq_continues, out_valid_o && out_ready_i && !last_byte_o, out_valid_o, "sequence cut short")
  `TLV_ASSERT_NEXT(a_held_request_stays, in_valid_q && !load, in_valid_q, "held request lost")

endmodule
